// ===== rtl/core/bop_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bop_pkg
// Shared types, constants and helper functions of the binomial option pricer.
// ----------------------------------------------------------------------------
package bop_pkg;

   localparam int unsigned PRICE_W    = 48;
   localparam int unsigned FACT_W     = 32;
   localparam int unsigned WGT_W      = 31;
   localparam int unsigned STEPS_W    = 8;
   localparam int unsigned PART_W     = 24;
   localparam int unsigned PROD_W     = PART_W + FACT_W;
   localparam int unsigned ACC_W      = 82;
   localparam int unsigned FRAC_SHIFT = 30;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 48;
   localparam int unsigned PH_W       = 4;

   localparam logic [ACC_W-1:0]   ACC_HALF  = ACC_W'(64'h2000_0000);
   localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};

   localparam logic [STEPS_W-1:0] RST_STEPS = 8'd100;
   localparam logic [FACT_W-1:0]  RST_ONE   = 32'h4000_0000;
   localparam logic [WGT_W-1:0]   RST_HALF  = 31'h2000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEPS,
      CSR_STRIKE,
      CSR_IS_CALL,
      CSR_IS_AMERICAN,
      CSR_UP_FACTOR,
      CSR_DOWN_FACTOR,
      CSR_DISC_UP_WEIGHT,
      CSR_DISC_DOWN_WEIGHT
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DOWN,
      ST_TERM_WR,
      ST_TERM_UP,
      ST_FOLD_RD0,
      ST_FOLD_HOLD,
      ST_NODE_RD,
      ST_NODE_LD,
      ST_NODE_MAC,
      ST_NODE_WR,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      PP_P_LO,
      PP_P_HI,
      PP_U_LO,
      PP_U_HI,
      PP_D_LO,
      PP_D_HI
   } pp_sel_type;

   typedef struct packed {
      logic [STEPS_W-1:0] steps;
      logic [PRICE_W-1:0] strike;
      logic               is_call;
      logic               is_american;
      logic [FACT_W-1:0]  up_factor;
      logic [FACT_W-1:0]  down_factor;
      logic [WGT_W-1:0]   disc_up_weight;
      logic [WGT_W-1:0]   disc_down_weight;
   } cfg_type;

   typedef struct packed {
      logic       accept;
      logic       mul_en;
      pp_sel_type pp_sel;
      logic       use_down;
      logic       acc_clr;
      logic       p_load_acc;
      logic       p_load_ram;
      logic       hold_load_ram;
      logic       hold_from_up;
      logic       vup_load_ram;
      logic       v_load_acc;
      logic       rd_en;
      logic       rd_val_j1;
      logic       wr_term;
      logic       wr_node;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic spot_zero;
   } sts_type;

   function automatic logic [PRICE_W-1:0] payoff(input logic [PRICE_W-1:0] price,
                                                 input logic [PRICE_W-1:0] strike,
                                                 input logic               is_call);
      logic [PRICE_W-1:0] res;
      if (is_call) begin
         res = (price > strike) ? price - strike : '0;
      end else begin
         res = (strike > price) ? strike - price : '0;
      end
      return res;
   endfunction

   function automatic logic [PRICE_W-1:0] sat_round(input logic [ACC_W-1:0] acc);
      logic [PRICE_W-1:0] res;
      if (acc[ACC_W-1:FRAC_SHIFT+PRICE_W] != '0) begin
         res = PRICE_MAX;
      end else begin
         res = acc[FRAC_SHIFT+PRICE_W-1:FRAC_SHIFT];
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bop_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bop_req_if
// Request channel: one spot price per item.
// ----------------------------------------------------------------------------
interface bop_req_if;
   logic                         valid;
   logic                         ready;
   logic [bop_pkg::PRICE_W-1:0]  spot_price;

   modport source (output valid, output spot_price, input ready);
   modport sink   (input valid, input spot_price, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bop_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bop_rsp_if
// Response channel: option value and status per item.
// ----------------------------------------------------------------------------
interface bop_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bop_pkg::PRICE_W-1:0]  fair_value;
   logic                         status;

   modport source (output valid, output fair_value, output status, input ready);
   modport sink   (input valid, input fair_value, input status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bop_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bop_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bop_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 129
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/bop_csr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bop_csr
// Configuration register file with write-only access.
// ----------------------------------------------------------------------------
module bop_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [bop_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bop_pkg::CSR_DATA_W-1:0]    csr_wr_data,
   output bop_pkg::cfg_type                       cfg
);

   bop_pkg::cfg_type cfg_ff;
   bop_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (bop_pkg::csr_index_type'(csr_index))
            bop_pkg::CSR_STEPS: begin
               cfg_in.steps = csr_wr_data[bop_pkg::STEPS_W-1:0];
            end
            bop_pkg::CSR_STRIKE: begin
               cfg_in.strike = csr_wr_data[bop_pkg::PRICE_W-1:0];
            end
            bop_pkg::CSR_IS_CALL: begin
               cfg_in.is_call = csr_wr_data[0];
            end
            bop_pkg::CSR_IS_AMERICAN: begin
               cfg_in.is_american = csr_wr_data[0];
            end
            bop_pkg::CSR_UP_FACTOR: begin
               cfg_in.up_factor = csr_wr_data[bop_pkg::FACT_W-1:0];
            end
            bop_pkg::CSR_DOWN_FACTOR: begin
               cfg_in.down_factor = csr_wr_data[bop_pkg::FACT_W-1:0];
            end
            bop_pkg::CSR_DISC_UP_WEIGHT: begin
               cfg_in.disc_up_weight = csr_wr_data[bop_pkg::WGT_W-1:0];
            end
            bop_pkg::CSR_DISC_DOWN_WEIGHT: begin
               cfg_in.disc_down_weight = csr_wr_data[bop_pkg::WGT_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.steps            <= bop_pkg::RST_STEPS;
         cfg_ff.strike           <= '0;
         cfg_ff.is_call          <= 1'b0;
         cfg_ff.is_american      <= 1'b0;
         cfg_ff.up_factor        <= bop_pkg::RST_ONE;
         cfg_ff.down_factor      <= bop_pkg::RST_ONE;
         cfg_ff.disc_up_weight   <= bop_pkg::RST_HALF;
         cfg_ff.disc_down_weight <= bop_pkg::RST_HALF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== rtl/core/bop_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bop_datapath
// Shared partial-product multiplier, accumulator, node registers and the
// price and value line memories.
// ----------------------------------------------------------------------------
module bop_datapath #(
   parameter int unsigned MAX_STEPS = 128
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire bop_pkg::cfg_type                      cfg,
   input  wire bop_pkg::cmd_type                      cmd,
   input  wire logic [$clog2(MAX_STEPS+1)-1:0]        j_idx,
   input  wire logic [bop_pkg::PRICE_W-1:0]           spot_price,
   output bop_pkg::sts_type                           sts,
   output logic      [bop_pkg::PRICE_W-1:0]           fair_value,
   output logic                                       status
);

   localparam int unsigned DEPTH = MAX_STEPS + 1;
   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned PW    = bop_pkg::PRICE_W;
   localparam int unsigned HW    = bop_pkg::PART_W;

   logic [PW-1:0]                 p_ff, p_in;
   logic [PW-1:0]                 vup_ff;
   logic [PW-1:0]                 hold_ff;
   logic [PW-1:0]                 v_ff;
   logic [PW-1:0]                 res_ff;
   logic                          stat_ff;
   logic [PW-1:0]                 out_val_ff;
   logic                          out_stat_ff;
   logic [bop_pkg::PROD_W-1:0]    prod_ff;
   logic                          prod_hi_ff;
   logic                          prod_vld_ff;
   logic [bop_pkg::ACC_W-1:0]     acc_ff, acc_in;

   logic [HW-1:0]                 part;
   logic [bop_pkg::FACT_W-1:0]    fac;
   logic                          part_hi;
   logic [PW-1:0]                 acc_sat;
   logic [PW-1:0]                 exer;
   logic [PW-1:0]                 vnew;
   logic [PW-1:0]                 price_rd, value_rd;
   logic [AW-1:0]                 val_rd_addr;
   logic                          wr_en;
   logic [PW-1:0]                 val_wr_data;

   always_comb begin
      part    = p_ff[HW-1:0];
      fac     = cmd.use_down ? cfg.down_factor : cfg.up_factor;
      part_hi = 1'b0;
      case (cmd.pp_sel)
         bop_pkg::PP_P_LO: begin
            part = p_ff[HW-1:0];
         end
         bop_pkg::PP_P_HI: begin
            part    = p_ff[PW-1:HW];
            part_hi = 1'b1;
         end
         bop_pkg::PP_U_LO: begin
            part = vup_ff[HW-1:0];
            fac  = {1'b0, cfg.disc_up_weight};
         end
         bop_pkg::PP_U_HI: begin
            part    = vup_ff[PW-1:HW];
            fac     = {1'b0, cfg.disc_up_weight};
            part_hi = 1'b1;
         end
         bop_pkg::PP_D_LO: begin
            part = hold_ff[HW-1:0];
            fac  = {1'b0, cfg.disc_down_weight};
         end
         bop_pkg::PP_D_HI: begin
            part    = hold_ff[PW-1:HW];
            fac     = {1'b0, cfg.disc_down_weight};
            part_hi = 1'b1;
         end
         default: begin
            part = p_ff[HW-1:0];
         end
      endcase
   end

   always_comb begin
      if (cmd.acc_clr) begin
         acc_in = bop_pkg::ACC_HALF;
      end else if (prod_vld_ff) begin
         if (prod_hi_ff) begin
            acc_in = acc_ff + bop_pkg::ACC_W'({prod_ff, {HW{1'b0}}});
         end else begin
            acc_in = acc_ff + bop_pkg::ACC_W'(prod_ff);
         end
      end else begin
         acc_in = acc_ff;
      end
   end

   assign acc_sat = bop_pkg::sat_round(acc_ff);
   assign exer    = bop_pkg::payoff(p_ff, cfg.strike, cfg.is_call);
   assign vnew    = (cfg.is_american && (exer > v_ff)) ? exer : v_ff;

   always_comb begin
      p_in = p_ff;
      if (cmd.accept) begin
         p_in = spot_price;
      end else if (cmd.p_load_acc) begin
         p_in = acc_sat;
      end else if (cmd.p_load_ram) begin
         p_in = price_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= cmd.mul_en;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= part * fac;
      prod_hi_ff <= part_hi;
      acc_ff     <= acc_in;
      p_ff       <= p_in;
      if (cmd.vup_load_ram) begin
         vup_ff <= value_rd;
      end
      if (cmd.hold_load_ram) begin
         hold_ff <= value_rd;
      end else if (cmd.hold_from_up) begin
         hold_ff <= vup_ff;
      end
      if (cmd.v_load_acc) begin
         v_ff <= acc_sat;
      end
      if (cmd.accept) begin
         res_ff  <= '0;
         stat_ff <= sts.spot_zero;
      end else if (cmd.wr_node) begin
         res_ff <= vnew;
      end
      if (cmd.out_load) begin
         out_val_ff  <= res_ff;
         out_stat_ff <= stat_ff;
      end
   end

   assign wr_en       = cmd.wr_term | cmd.wr_node;
   assign val_wr_data = cmd.wr_term ? exer : vnew;
   assign val_rd_addr = cmd.rd_val_j1 ? j_idx + AW'(1) : '0;

   bop_ram #(
      .WIDTH (PW),
      .DEPTH (DEPTH)
   ) u_price_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (j_idx),
      .wr_data (p_ff),
      .rd_en   (cmd.rd_en),
      .rd_addr (j_idx),
      .rd_data (price_rd)
   );

   bop_ram #(
      .WIDTH (PW),
      .DEPTH (DEPTH)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (j_idx),
      .wr_data (val_wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (val_rd_addr),
      .rd_data (value_rd)
   );

   assign sts.spot_zero = (spot_price == '0);
   assign fair_value    = out_val_ff;
   assign status        = out_stat_ff;

endmodule
`default_nettype wire

// ===== rtl/core/bop_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bop_ctrl
// Sequencer for terminal line set-up, backward fold and result hand-off.
// ----------------------------------------------------------------------------
module bop_ctrl #(
   parameter int unsigned MAX_STEPS = 128
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [bop_pkg::STEPS_W-1:0]           steps,
   input  wire bop_pkg::sts_type                      sts,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output bop_pkg::cmd_type                           cmd,
   output logic      [$clog2(MAX_STEPS+1)-1:0]        j_idx
);

   localparam int unsigned CW = $clog2(MAX_STEPS + 1);
   localparam int unsigned SW = (CW > bop_pkg::STEPS_W) ? CW : bop_pkg::STEPS_W;

   bop_pkg::state_type         state_ff, state_in;
   logic [bop_pkg::PH_W-1:0]   ph_ff, ph_in;
   logic [CW-1:0]              n_ff, n_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic [CW-1:0]              i_ff, i_in;
   logic [CW-1:0]              j_ff, j_in;
   logic                       out_vld_ff, out_vld_in;
   logic [SW-1:0]              steps_ext;
   logic [CW-1:0]              n_clamp;

   assign steps_ext = SW'(steps);
   assign n_clamp   = (steps_ext == '0) ? CW'(1) :
                      (steps_ext > SW'(MAX_STEPS)) ? CW'(MAX_STEPS) : CW'(steps_ext);

   always_comb begin
      state_in  = state_ff;
      ph_in     = ph_ff;
      n_in      = n_ff;
      cnt_in    = cnt_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         bop_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               n_in       = n_clamp;
               cnt_in     = n_clamp;
               j_in       = '0;
               ph_in      = '0;
               state_in   = sts.spot_zero ? bop_pkg::ST_FINISH : bop_pkg::ST_DOWN;
            end
         end
         bop_pkg::ST_DOWN: begin
            cmd.use_down = 1'b1;
            ph_in        = ph_ff + 1'b1;
            case (ph_ff)
               4'd0: begin
                  cmd.acc_clr = 1'b1;
                  cmd.mul_en  = 1'b1;
                  cmd.pp_sel  = bop_pkg::PP_P_LO;
               end
               4'd1: begin
                  cmd.mul_en = 1'b1;
                  cmd.pp_sel = bop_pkg::PP_P_HI;
               end
               4'd3: begin
                  cmd.p_load_acc = 1'b1;
                  cnt_in         = cnt_ff - 1'b1;
                  ph_in          = '0;
                  if (cnt_ff == CW'(1)) begin
                     state_in = bop_pkg::ST_TERM_WR;
                  end
               end
               default: begin
                  cmd.mul_en = 1'b0;
               end
            endcase
         end
         bop_pkg::ST_TERM_WR: begin
            cmd.wr_term = 1'b1;
            ph_in       = '0;
            if (j_ff == n_ff) begin
               i_in     = n_ff - 1'b1;
               state_in = bop_pkg::ST_FOLD_RD0;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = bop_pkg::ST_TERM_UP;
            end
         end
         bop_pkg::ST_TERM_UP: begin
            ph_in = ph_ff + 1'b1;
            case (ph_ff)
               4'd0, 4'd4: begin
                  cmd.acc_clr = 1'b1;
                  cmd.mul_en  = 1'b1;
                  cmd.pp_sel  = bop_pkg::PP_P_LO;
               end
               4'd1, 4'd5: begin
                  cmd.mul_en = 1'b1;
                  cmd.pp_sel = bop_pkg::PP_P_HI;
               end
               4'd3: begin
                  cmd.p_load_acc = 1'b1;
               end
               4'd7: begin
                  cmd.p_load_acc = 1'b1;
                  ph_in          = '0;
                  state_in       = bop_pkg::ST_TERM_WR;
               end
               default: begin
                  cmd.mul_en = 1'b0;
               end
            endcase
         end
         bop_pkg::ST_FOLD_RD0: begin
            cmd.rd_en = 1'b1;
            j_in      = '0;
            state_in  = bop_pkg::ST_FOLD_HOLD;
         end
         bop_pkg::ST_FOLD_HOLD: begin
            cmd.hold_load_ram = 1'b1;
            state_in          = bop_pkg::ST_NODE_RD;
         end
         bop_pkg::ST_NODE_RD: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_val_j1 = 1'b1;
            state_in      = bop_pkg::ST_NODE_LD;
         end
         bop_pkg::ST_NODE_LD: begin
            cmd.vup_load_ram = 1'b1;
            cmd.p_load_ram   = 1'b1;
            ph_in            = '0;
            state_in         = bop_pkg::ST_NODE_MAC;
         end
         bop_pkg::ST_NODE_MAC: begin
            ph_in = ph_ff + 1'b1;
            case (ph_ff)
               4'd0: begin
                  cmd.acc_clr = 1'b1;
                  cmd.mul_en  = 1'b1;
                  cmd.pp_sel  = bop_pkg::PP_U_LO;
               end
               4'd1: begin
                  cmd.mul_en = 1'b1;
                  cmd.pp_sel = bop_pkg::PP_U_HI;
               end
               4'd2: begin
                  cmd.mul_en = 1'b1;
                  cmd.pp_sel = bop_pkg::PP_D_LO;
               end
               4'd3: begin
                  cmd.mul_en = 1'b1;
                  cmd.pp_sel = bop_pkg::PP_D_HI;
               end
               4'd5: begin
                  cmd.v_load_acc = 1'b1;
                  cmd.acc_clr    = 1'b1;
                  cmd.mul_en     = 1'b1;
                  cmd.pp_sel     = bop_pkg::PP_P_LO;
               end
               4'd6: begin
                  cmd.mul_en = 1'b1;
                  cmd.pp_sel = bop_pkg::PP_P_HI;
               end
               4'd8: begin
                  cmd.p_load_acc = 1'b1;
                  ph_in          = '0;
                  state_in       = bop_pkg::ST_NODE_WR;
               end
               default: begin
                  cmd.mul_en = 1'b0;
               end
            endcase
         end
         bop_pkg::ST_NODE_WR: begin
            cmd.wr_node      = 1'b1;
            cmd.hold_from_up = 1'b1;
            if (j_ff == i_ff) begin
               if (i_ff == '0) begin
                  state_in = bop_pkg::ST_FINISH;
               end else begin
                  i_in     = i_ff - 1'b1;
                  state_in = bop_pkg::ST_FOLD_RD0;
               end
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = bop_pkg::ST_NODE_RD;
            end
         end
         bop_pkg::ST_FINISH: begin
            if (!out_vld_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = bop_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bop_pkg::ST_IDLE;
         end
      endcase
   end

   assign out_vld_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : out_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bop_pkg::ST_IDLE;
         ph_ff      <= '0;
         n_ff       <= '0;
         cnt_ff     <= '0;
         i_ff       <= '0;
         j_ff       <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ph_ff      <= ph_in;
         n_ff       <= n_in;
         cnt_ff     <= cnt_in;
         i_ff       <= i_in;
         j_ff       <= j_in;
         out_vld_ff <= out_vld_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign j_idx     = j_ff;

   a_node_in_level: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bop_pkg::ST_NODE_RD) |-> (j_ff <= i_ff))
      else $error("node index beyond level");

   a_down_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bop_pkg::ST_DOWN) |-> (cnt_ff != '0))
      else $error("down count exhausted in down phase");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!out_vld_ff || rsp_ready))
      else $error("result overwritten before taken");

   a_term_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bop_pkg::ST_TERM_WR) |-> (j_ff <= n_ff))
      else $error("terminal index beyond step count");

endmodule
`default_nettype wire

// ===== rtl/core/binomial_tree_option_pricer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// binomial_tree_option_pricer
// Recombining binomial tree option pricer, one value per spot price.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one spot price per item (valid/ready). rsp_ch returns the
//   root value and a status bit; status 1 with value 0 flags a zero spot.
//   csr_* writes the tree configuration; write only while the block is idle.
// Sequence, n = clamped step count:
//   zero spot: taken straight to the finish state and output register.
//   otherwise n down steps, the terminal line, then the backward fold; every
//   product goes through one shared 24x32 multiplier in partial products,
//   six per node of the fold, with the price and value lines in RAMs.
// Throughput: one item in flight; the next item is taken once the result
//   sits in the output register.
// Reset: CSR and control registers return to defaults; lines need no clearing.
// Stall: a result held by the receiver waits in the output register; a new
//   item can run meanwhile and waits at its end until the register frees.
// ----------------------------------------------------------------------------
module binomial_tree_option_pricer #(
   parameter int unsigned MAX_STEPS = 128
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   bop_req_if.sink                                req_ch,
   bop_rsp_if.source                              rsp_ch,
   input  wire logic                              csr_wr_en,
   input  wire logic [bop_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bop_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   localparam int unsigned AW = $clog2(MAX_STEPS + 1);

   bop_pkg::cfg_type cfg;
   bop_pkg::cmd_type cmd;
   bop_pkg::sts_type sts;
   logic [AW-1:0]    j_idx;

   bop_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   bop_ctrl #(
      .MAX_STEPS (MAX_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .steps     (cfg.steps),
      .sts       (sts),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .j_idx     (j_idx)
   );

   bop_datapath #(
      .MAX_STEPS (MAX_STEPS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .j_idx      (j_idx),
      .spot_price (req_ch.spot_price),
      .sts        (sts),
      .fair_value (rsp_ch.fair_value),
      .status     (rsp_ch.status)
   );

endmodule
`default_nettype wire
